// ===== src/assert_macros.svh =====
// Assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bmp24_pkg.sv =====
// Package: constants, result codes and shared types of the BMP stream decoder
package bmp24_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;
    localparam logic [31:0] HEADER_LAST   = 32'd53;
    localparam logic [15:0] BPP_24        = 16'd24;

    // result kinds
    localparam logic [1:0] KIND_PIXEL      = 2'd0;
    localparam logic [1:0] KIND_BAD_SIG    = 2'd1;
    localparam logic [1:0] KIND_BAD_FORMAT = 2'd2;
    localparam logic [1:0] KIND_BAD_SIZE   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       top_down;
        logic       zero_height;
        logic       direct_pixels;
    } t_hdr_chk;

endpackage

// ===== src/bmp24_ifs.sv =====
// Stream interfaces: input byte channel and output pixel channel
interface bmp24_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmp24_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] dest_row;
    logic [11:0] dest_column;
    logic        image_done;

    modport source (output valid, output kind, output red, output green, output blue,
                    output dest_row, output dest_column, output image_done, input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    input dest_row, input dest_column, input image_done, output ready);
endinterface

// ===== src/bmp24_hdr_chk.sv =====
// Header check: validates the captured header fields and gives the error kind
module bmp24_hdr_chk #(
    parameter int MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
    input  logic [15:0]         i_signature,
    input  logic [31:0]         i_offset,
    input  logic [31:0]         i_width,
    input  logic [31:0]         i_height,
    input  logic [15:0]         i_bpp,
    input  logic [31:0]         i_comp,
    output bmp24_pkg::t_hdr_chk o_chk,
    output logic [31:0]         o_height_mag
);

    logic w_neg;
    logic w_bad_size;

    assign w_neg        = i_height[31];
    assign o_height_mag = w_neg ? (~i_height + 32'd1) : i_height;

    assign w_bad_size = (i_offset < bmp24_pkg::HEADER_BYTES)
                     || (i_width == 32'd0) || i_width[31]
                     || (i_width > 32'(MAX_WIDTH))
                     || (o_height_mag > 32'(MAX_HEIGHT));

    always_comb begin
        o_chk.top_down      = w_neg;
        o_chk.zero_height   = (o_height_mag == 32'd0);
        o_chk.direct_pixels = (i_offset == bmp24_pkg::HEADER_BYTES);
        if (i_signature != bmp24_pkg::BMP_SIGNATURE) begin
            o_chk.kind = bmp24_pkg::KIND_BAD_SIG;
        end else if ((i_bpp != bmp24_pkg::BPP_24) || (i_comp != 32'd0)) begin
            o_chk.kind = bmp24_pkg::KIND_BAD_FORMAT;
        end else if (w_bad_size) begin
            o_chk.kind = bmp24_pkg::KIND_BAD_SIZE;
        end else begin
            o_chk.kind = bmp24_pkg::KIND_PIXEL;
        end
    end

endmodule

// ===== src/bmp24_stream_decoder_unit.sv =====
// Top level: streaming decoder for uncompressed 24-bit BMP files
//
//  channel   dir  handshake      payload
//  i_byte    in   valid/ready    data_byte[7:0], first_byte
//  o_pix     out  valid/ready    kind[1:0], red, green, blue, dest_row[11:0],
//                                dest_column[11:0], image_done
//
// One byte per cycle; every byte updates the parse state in the cycle it is taken.
// A result appears on o_pix the cycle after its third colour byte (or byte 53 for
// a header error) and sits in a single output register.
// i_byte.ready is low only while that register is full and o_pix.ready is low.
// Reset is synchronous (i_rst_n low); after it the decoder expects byte 0 of a file.
`include "assert_macros.svh"

module bmp24_stream_decoder_unit #(
    parameter int MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bmp24_byte_if.sink       i_byte,
    bmp24_pix_if.source      o_pix
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    // control state
    logic [2:0]    r_phase, n_phase;
    logic [31:0]   r_pos, n_pos;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [1:0]    r_bip, n_bip;
    logic [1:0]    r_pad, n_pad;
    logic          r_out_valid;

    // header fields and derived image geometry
    logic [15:0]   r_sig;
    logic [31:0]   r_off, r_wid, r_hgt, r_comp;
    logic [15:0]   r_bpp;
    logic          r_top, n_top;
    logic [RW-1:0] r_rows, n_rows;
    logic [CW-1:0] r_cols, n_cols;
    logic [7:0]    r_blue, r_green;

    // output register
    logic [1:0]    r_kind, n_kind;
    logic [7:0]    r_red, n_red, r_ogreen, n_ogreen, r_oblue, n_oblue;
    logic [11:0]   r_orow, n_orow, r_ocol, n_ocol;
    logic          r_done, n_done;
    logic          w_emit;

    logic          w_accept;
    logic          w_first;
    logic [2:0]    w_phase;
    logic [31:0]   w_pos;
    logic [7:0]    w_b;

    bmp24_pkg::t_hdr_chk w_chk;
    logic [31:0]         w_mag;
    logic [RW-1:0]       w_row_calc;
    logic [31:0]         w_row_ext, w_col_ext;
    logic                w_last_col, w_last_row;

    bmp24_hdr_chk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr_chk (
        .i_signature  (r_sig),
        .i_offset     (r_off),
        .i_width      (r_wid),
        .i_height     (r_hgt),
        .i_bpp        (r_bpp),
        .i_comp       (r_comp),
        .o_chk        (w_chk),
        .o_height_mag (w_mag)
    );

    assign i_byte.ready = !r_out_valid || o_pix.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_first      = i_byte.first_byte;
    assign w_b          = i_byte.data_byte;

    // a first-marked byte restarts the parse at byte 0
    assign w_phase = w_first ? PH_HEADER : r_phase;
    assign w_pos   = w_first ? 32'd0 : r_pos;

    assign w_row_calc = r_top ? r_row : (r_rows - RW'(1) - r_row);
    assign w_row_ext  = 32'(w_row_calc);
    assign w_col_ext  = 32'(r_col);
    assign w_last_col = (r_col == r_cols - CW'(1));
    assign w_last_row = (r_row == r_rows - RW'(1));

    always_comb begin
        n_phase  = w_phase;
        n_pos    = w_pos;
        n_row    = w_first ? '0 : r_row;
        n_col    = w_first ? '0 : r_col;
        n_bip    = w_first ? 2'd0 : r_bip;
        n_pad    = w_first ? 2'd0 : r_pad;
        n_top    = r_top;
        n_rows   = r_rows;
        n_cols   = r_cols;
        w_emit   = 1'b0;
        n_kind   = bmp24_pkg::KIND_PIXEL;
        n_red    = 8'd0;
        n_ogreen = 8'd0;
        n_oblue  = 8'd0;
        n_orow   = 12'd0;
        n_ocol   = 12'd0;
        n_done   = 1'b0;
        case (w_phase)
            PH_HEADER: begin
                n_pos = w_pos + 32'd1;
                if (w_pos == bmp24_pkg::HEADER_LAST) begin
                    n_row = '0;
                    n_col = '0;
                    n_bip = 2'd0;
                    n_pad = 2'd0;
                    n_top = w_chk.top_down;
                    if (w_chk.kind != bmp24_pkg::KIND_PIXEL) begin
                        n_phase = PH_IDLE;
                        w_emit  = 1'b1;
                        n_kind  = w_chk.kind;
                    end else begin
                        n_rows = w_mag[RW-1:0];
                        n_cols = r_wid[CW-1:0];
                        if (w_chk.zero_height) begin
                            n_phase = PH_IDLE;
                        end else if (w_chk.direct_pixels) begin
                            n_phase = PH_PIXEL;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_pos = r_pos + 32'd1;
                if (n_pos == r_off) begin
                    n_phase = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                case (r_bip)
                    2'd0: n_bip = 2'd1;
                    2'd1: n_bip = 2'd2;
                    default: begin
                        n_bip    = 2'd0;
                        w_emit   = 1'b1;
                        n_red    = w_b;
                        n_ogreen = r_green;
                        n_oblue  = r_blue;
                        n_orow   = w_row_ext[11:0];
                        n_ocol   = w_col_ext[11:0];
                        n_done   = w_last_col && w_last_row;
                        if (!w_last_col) begin
                            n_col = r_col + CW'(1);
                        end else if (w_last_row) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_col = '0;
                            n_row = r_row + RW'(1);
                            n_pad = r_wid[1:0];
                            if (r_wid[1:0] != 2'd0) begin
                                n_phase = PH_PAD;
                            end
                        end
                    end
                endcase
            end
            PH_PAD: begin
                n_pad = r_pad - 2'd1;
                if (n_pad == 2'd0) begin
                    n_phase = PH_PIXEL;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= 32'd0;
            r_row       <= '0;
            r_col       <= '0;
            r_bip       <= 2'd0;
            r_pad       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_row   <= n_row;
                r_col   <= n_col;
                r_bip   <= n_bip;
                r_pad   <= n_pad;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // header capture, little-endian
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_phase == PH_HEADER)) begin
            case (w_pos[5:0])
                6'd0:  r_sig[7:0]    <= w_b;
                6'd1:  r_sig[15:8]   <= w_b;
                6'd10: r_off[7:0]    <= w_b;
                6'd11: r_off[15:8]   <= w_b;
                6'd12: r_off[23:16]  <= w_b;
                6'd13: r_off[31:24]  <= w_b;
                6'd18: r_wid[7:0]    <= w_b;
                6'd19: r_wid[15:8]   <= w_b;
                6'd20: r_wid[23:16]  <= w_b;
                6'd21: r_wid[31:24]  <= w_b;
                6'd22: r_hgt[7:0]    <= w_b;
                6'd23: r_hgt[15:8]   <= w_b;
                6'd24: r_hgt[23:16]  <= w_b;
                6'd25: r_hgt[31:24]  <= w_b;
                6'd28: r_bpp[7:0]    <= w_b;
                6'd29: r_bpp[15:8]   <= w_b;
                6'd30: r_comp[7:0]   <= w_b;
                6'd31: r_comp[15:8]  <= w_b;
                6'd32: r_comp[23:16] <= w_b;
                6'd33: r_comp[31:24] <= w_b;
                default: ;
            endcase
        end
    end

    // geometry, held colour bytes and the output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top  <= n_top;
            r_rows <= n_rows;
            r_cols <= n_cols;
            if (w_phase == PH_PIXEL) begin
                if (r_bip == 2'd0) begin
                    r_blue <= w_b;
                end
                if (r_bip == 2'd1) begin
                    r_green <= w_b;
                end
            end
        end
        if (w_accept && w_emit) begin
            r_kind   <= n_kind;
            r_red    <= n_red;
            r_ogreen <= n_ogreen;
            r_oblue  <= n_oblue;
            r_orow   <= n_orow;
            r_ocol   <= n_ocol;
            r_done   <= n_done;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.kind        = r_kind;
    assign o_pix.red         = r_red;
    assign o_pix.green       = r_ogreen;
    assign o_pix.blue        = r_oblue;
    assign o_pix.dest_row    = r_orow;
    assign o_pix.dest_column = r_ocol;
    assign o_pix.image_done  = r_done;

    `ASSERT_CLK(a_err_blank, i_clk, i_rst_n, (r_out_valid && (r_kind != bmp24_pkg::KIND_PIXEL)) |-> ((r_red == 8'd0) && (r_ogreen == 8'd0) && (r_oblue == 8'd0) && (r_orow == 12'd0) && (r_ocol == 12'd0) && !r_done), "error item carries a non-zero payload")
    `ASSERT_CLK(a_done_is_pixel, i_clk, i_rst_n, (r_out_valid && r_done) |-> (r_kind == bmp24_pkg::KIND_PIXEL), "image_done set on an error item")
    `ASSERT_CLK(a_bip_range, i_clk, i_rst_n, r_bip != 2'd3, "pixel byte counter out of range")
    `ASSERT_CLK_ALWAYS(a_free_when_empty, i_clk, !r_out_valid |-> i_byte.ready, "input stalled with empty output register")

endmodule

// ===== verif/bmp24_stream_decoder_unit_tb.sv =====
// Testbench for the BMP stream decoder: byte streams in, predicted pixels and errors checked out
module bmp24_stream_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmp24_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SKIP_TO_DATA,
        PH_COLOUR,
        PH_ROW_PAD,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] dest_row;
        logic [11:0] dest_column;
        logic        image_done;
    } decoded_t;

    localparam int IMG_MAX_W = MAX_WIDTH_DEF;
    localparam int IMG_MAX_H = MAX_HEIGHT_DEF;

    logic i_clk;
    logic i_rst_n;

    bmp24_byte_if byte_ch();
    bmp24_pix_if  pix_ch();

    bmp24_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pix   (pix_ch)
    );

    // decoder state as predicted
    logic [31:0]  hdr_pos;
    logic [15:0]  magic;
    logic [31:0]  data_offset;
    logic [31:0]  img_width;
    logic [31:0]  img_height;
    logic [15:0]  bpp;
    logic [31:0]  compression;
    logic         rows_top_down;
    parse_phase_t parse_phase;
    logic [31:0]  cur_row;
    logic [31:0]  cur_col;
    logic [1:0]   colour_idx;
    logic [7:0]   blue_hold;
    logic [7:0]   green_hold;
    logic [1:0]   pad_left;

    decoded_t   pending_results[$];
    logic [7:0] file_bytes[$];
    int         mismatch_count;
    int         bytes_sent;
    int         tx_gap_pct;
    int         rx_stall_pct;
    int         rx_hold_req;
    int         rx_hold_left;
    int         rx_pause;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(50_000_000);
        $display("bmp24_stream_decoder_unit: mismatch");
        $finish;
    end

    function automatic void clear_decoder();
        hdr_pos       = '0;
        magic         = '0;
        data_offset   = '0;
        img_width     = '0;
        img_height    = '0;
        bpp           = '0;
        compression   = '0;
        rows_top_down = 1'b0;
        parse_phase   = PH_HDR;
        cur_row       = '0;
        cur_col       = '0;
        colour_idx    = '0;
        blue_hold     = '0;
        green_hold    = '0;
        pad_left      = '0;
    endfunction

    // signature first, then format, then size and offset
    function automatic logic [1:0] check_header();
        logic [31:0] mag;
        if (magic != BMP_SIGNATURE) return KIND_BAD_SIG;
        if (bpp != BPP_24 || compression != 32'd0) return KIND_BAD_FORMAT;
        rows_top_down = img_height[31];
        mag = img_height[31] ? -img_height : img_height;
        if (data_offset < HEADER_BYTES) return KIND_BAD_SIZE;
        if (img_width == 32'd0 || img_width[31] || img_width > IMG_MAX_W) return KIND_BAD_SIZE;
        if (mag > IMG_MAX_H) return KIND_BAD_SIZE;
        img_height = mag;
        return KIND_PIXEL;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       output decoded_t res);
        logic [31:0] p;
        logic [31:0] row;
        logic [1:0]  err;
        logic        last_col;
        logic        last_row;
        res = '0;
        if (first) clear_decoder();
        case (parse_phase)
            PH_HDR: begin
                p = hdr_pos;
                if (p <= 1) magic[8*p +: 8] = b;
                else if (p >= 10 && p <= 13) data_offset[8*(p-10) +: 8] = b;
                else if (p >= 18 && p <= 21) img_width[8*(p-18) +: 8] = b;
                else if (p >= 22 && p <= 25) img_height[8*(p-22) +: 8] = b;
                else if (p >= 28 && p <= 29) bpp[8*(p-28) +: 8] = b;
                else if (p >= 30 && p <= 33) compression[8*(p-30) +: 8] = b;
                hdr_pos = p + 1;
                if (p == HEADER_LAST) begin
                    err = check_header();
                    if (err != KIND_PIXEL) begin
                        parse_phase = PH_DONE;
                        res.kind = err;
                        return 1'b1;
                    end
                    if (img_height == 32'd0) parse_phase = PH_DONE;
                    else if (data_offset == HEADER_BYTES) parse_phase = PH_COLOUR;
                    else parse_phase = PH_SKIP_TO_DATA;
                end
                return 1'b0;
            end
            PH_SKIP_TO_DATA: begin
                hdr_pos = hdr_pos + 1;
                if (hdr_pos == data_offset) parse_phase = PH_COLOUR;
                return 1'b0;
            end
            PH_COLOUR: begin
                if (colour_idx == 2'd0) begin
                    blue_hold = b;
                    colour_idx = 2'd1;
                    return 1'b0;
                end
                if (colour_idx == 2'd1) begin
                    green_hold = b;
                    colour_idx = 2'd2;
                    return 1'b0;
                end
                row = rows_top_down ? cur_row : img_height - 1 - cur_row;
                last_col = (cur_col + 1 == img_width);
                last_row = (cur_row + 1 == img_height);
                res.kind        = KIND_PIXEL;
                res.red         = b;
                res.green       = green_hold;
                res.blue        = blue_hold;
                res.dest_row    = row[11:0];
                res.dest_column = cur_col[11:0];
                res.image_done  = last_col && last_row;
                colour_idx = 2'd0;
                if (!last_col) begin
                    cur_col = cur_col + 1;
                end else if (last_row) begin
                    parse_phase = PH_DONE;
                end else begin
                    cur_col = '0;
                    cur_row = cur_row + 1;
                    pad_left = img_width[1:0];
                    if (pad_left != 2'd0) parse_phase = PH_ROW_PAD;
                end
                return 1'b1;
            end
            PH_ROW_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0) parse_phase = PH_COLOUR;
                return 1'b0;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int       gap;
        decoded_t res;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.first_byte <= first;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        if (decode_byte(b, first, res)) pending_results.push_back(res);
        bytes_sent++;
    endtask

    function automatic void poke_field(input int pos, input int nbytes, input logic [31:0] v);
        for (int i = 0; i < nbytes; i++) file_bytes[pos + i] = v[8*i +: 8];
    endfunction

    // reserved header bytes stay random
    function automatic void make_header(input logic [15:0] sig, input logic [31:0] offs,
                                        input logic [31:0] w, input logic [31:0] h,
                                        input logic [15:0] bits, input logic [31:0] comp);
        file_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++) file_bytes.push_back(8'($urandom));
        poke_field(0, 2, 32'(sig));
        poke_field(10, 4, offs);
        poke_field(18, 4, w);
        poke_field(22, 4, h);
        poke_field(28, 2, 32'(bits));
        poke_field(30, 4, comp);
    endfunction

    function automatic void add_random(input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_pixels(input int offs, input int w, input int rows);
        add_random(offs - int'(HEADER_BYTES));
        for (int r = 0; r < rows; r++) add_random(w * 3 + w % 4);
    endfunction

    task automatic send_file(input logic mark);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], (i == 0) ? mark : 1'b0);
    endtask

    task automatic send_image(input int w, input int h, input int offs, input int rows,
                              input int trail, input logic mark);
        make_header(BMP_SIGNATURE, offs, w, h, BPP_24, 32'd0);
        add_pixels(offs, w, rows);
        add_random(trail);
        send_file(mark);
    endtask

    task automatic send_bad_header(input logic [15:0] sig, input logic [31:0] offs,
                                   input logic [31:0] w, input logic [31:0] h,
                                   input logic [15:0] bits, input logic [31:0] comp);
        make_header(sig, offs, w, h, bits, comp);
        // bytes after the error must be dropped
        add_random(2);
        send_file(1'b1);
    endtask

    task automatic test_no_first_mark();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_image(2, 2, 54, 2, 0, 1'b0);
    endtask

    task automatic test_header_errors();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        send_bad_header(16'h4D43, 54, 2, 2, 16'd32, 32'd0);
        send_bad_header(16'h424D, 54, 2, 2, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 10, 0, 2, 16'd8, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 2, 2, BPP_24, 32'd1);
        send_bad_header(BMP_SIGNATURE, 53, 2, 2, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 32'd0, 2, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 32'hFFFF_FFFF, 2, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, IMG_MAX_W + 1, 2, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 2, IMG_MAX_H + 1, BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 2, -(IMG_MAX_H + 1), BPP_24, 32'd0);
        send_bad_header(BMP_SIGNATURE, 54, 2, 32'h8000_0000, BPP_24, 32'd0);
    endtask

    task automatic test_orientation();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send_image(3, 2, 54, 2, 3, 1'b1);
        send_image(2, -3, 54, 3, 0, 1'b1);
        // zero height: header accepted, the rest ignored
        send_image(2, 0, 54, 0, 10, 1'b1);
        // tall images cut short by the next file; the bottom-up one reaches the top row numbers
        send_image(1, IMG_MAX_H, 54, 3, 0, 1'b1);
        send_image(1, -IMG_MAX_H, 54, 3, 0, 1'b1);
    endtask

    task automatic test_padding_and_offset();
        tx_gap_pct   = 10;
        rx_stall_pct = 40;
        for (int w = 1; w <= 4; w++) send_image(w, 2, 54 + 2 * w, 2, 4, 1'b1);
        send_image(5, -2, 120, 2, 2, 1'b1);
    endtask

    task automatic test_widest_row();
        tx_gap_pct   = 5;
        rx_stall_pct = 5;
        // widest accepted header; the row is cut short by the next file
        make_header(BMP_SIGNATURE, 54, IMG_MAX_W, 1, BPP_24, 32'd0);
        add_random(3 * 20);
        send_file(1'b1);
    endtask

    task automatic test_output_stall();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 400;
        send_image(4, 4, 54, 4, 0, 1'b1);
    endtask

    task automatic test_random_streams();
        int   stop_at;
        int   sel;
        int   w;
        int   hmag;
        int   h;
        int   offs;
        int   rows;
        int   n;
        logic mark;
        stop_at = bytes_sent + 200;
        while (bytes_sent < stop_at) begin
            tx_gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
            rx_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
            sel = $urandom_range(99);
            if (sel < 70) begin
                w    = $urandom_range(9, 1);
                hmag = $urandom_range(6);
                h    = $urandom_range(1) ? -hmag : hmag;
                offs = $urandom_range(1) ? 54 : $urandom_range(62, 55);
                rows = ($urandom_range(9) == 0) ? $urandom_range(hmag) : hmag;
                mark = ($urandom_range(19) != 0);
                send_image(w, h, offs, rows, $urandom_range(5), mark);
            end else if (sel < 85) begin
                make_header(BMP_SIGNATURE, 54, $urandom_range(6, 1), $urandom_range(4),
                            BPP_24, 32'd0);
                case ($urandom_range(5))
                    0: poke_field(0, 2, $urandom);
                    1: poke_field(28, 2, $urandom_range(1) ? 32'd24 : $urandom);
                    2: poke_field(30, 4, $urandom);
                    3: poke_field(10, 4, $urandom_range(60));
                    4: poke_field(18, 4, $urandom_range(1) ? $urandom : IMG_MAX_W + 1);
                    default: poke_field(22, 4, $urandom);
                endcase
                add_random($urandom_range(20));
                send_file(1'b1);
            end else begin
                n = $urandom_range(40, 1);
                for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(99) < 3);
            end
        end
    endtask

    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pix_ch.ready <= 1'b0;
            end else if (rx_pause > 0) begin
                rx_pause--;
                pix_ch.ready <= 1'b0;
            end else begin
                rx_pause = pick_gap(rx_stall_pct);
                pix_ch.ready <= (rx_pause == 0);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        decoded_t got;
        decoded_t want;
        bit       unexpected;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            got = {pix_ch.kind, pix_ch.red, pix_ch.green, pix_ch.blue,
                   pix_ch.dest_row, pix_ch.dest_column, pix_ch.image_done};
            unexpected = (pending_results.size() == 0);
            want = unexpected ? 'x : pending_results.pop_front();
            if (unexpected || got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: expected kind=%0d rgb=%h/%h/%h row=%0d col=%0d done=%b",
                             $realtime, want.kind, want.red, want.green, want.blue,
                             want.dest_row, want.dest_column, want.image_done);
                    $display("%0t:      got kind=%0d rgb=%h/%h/%h row=%0d col=%0d done=%b",
                             $realtime, got.kind, got.red, got.green, got.blue,
                             got.dest_row, got.dest_column, got.image_done);
                end
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= 8'd0;
        byte_ch.first_byte <= 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        rx_hold_req    = 0;
        rx_hold_left   = 0;
        rx_pause       = 0;
        clear_decoder();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_first_mark();
        test_header_errors();
        test_orientation();
        test_padding_and_offset();
        test_widest_row();
        test_output_stall();
        test_random_streams();

        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bmp24_stream_decoder_unit: match");
        else
            $display("bmp24_stream_decoder_unit: mismatch");
        $finish;
    end

endmodule
